### hdl/stl_pkg.sv
`default_nettype none

package stl_pkg;

	localparam int LINE_BITS_DEF = 24;
	localparam int LINE_W        = 24;
	localparam int DEPTH         = 4;

	// lexer modes
	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_STR     = 3'd1;
	localparam logic [2:0] M_STR_ESC = 3'd2;
	localparam logic [2:0] M_CHR     = 3'd3;
	localparam logic [2:0] M_CHR_ESC = 3'd4;
	localparam logic [2:0] M_NUM     = 3'd5;
	localparam logic [2:0] M_IDENT   = 3'd6;

	// token kinds
	localparam logic [2:0] K_END    = 3'd0;
	localparam logic [2:0] K_STRING = 3'd1;
	localparam logic [2:0] K_CHAR   = 3'd2;
	localparam logic [2:0] K_INT    = 3'd3;
	localparam logic [2:0] K_FLOAT  = 3'd4;
	localparam logic [2:0] K_IDENT  = 3'd5;
	localparam logic [2:0] K_OTHER  = 3'd6;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_USCORE = 8'h5F;

	localparam logic [0:0] REG_FIRST_LINE = 1'b0;

	typedef struct packed {
		logic [2:0]        kind;
		logic              has_byte;
		logic [7:0]        value_byte;
		logic              token_end;
		logic [LINE_W-1:0] line;
	} res_t;

	typedef struct packed {
		logic       emit;
		logic [2:0] kind;
		logic       token_end;
		logic [2:0] mode;
		logic       newline;
	} start_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic [7:0] map_escape(input logic [7:0] c);
		case (c)
			8'h61:   return 8'h07; // a
			8'h62:   return 8'h08; // b
			8'h66:   return 8'h0C; // f
			8'h6E:   return 8'h0A; // n
			8'h72:   return 8'h0D; // r
			8'h74:   return 8'h09; // t
			8'h76:   return 8'h0B; // v
			default: return c;
		endcase
	endfunction

	// handling of a byte that arrives between tokens
	function automatic start_t start_tok(input logic [7:0] c);
		start_t s;
		s = '{emit: 1'b0, kind: K_OTHER, token_end: 1'b0, mode: M_IDLE, newline: 1'b0};
		if (c <= CH_SPACE) begin
			s.newline = (c == CH_NL);
		end else if (c == CH_QUOTE) begin
			s.mode = M_STR;
		end else if (c == CH_APOS) begin
			s.mode = M_CHR;
		end else if (is_digit(c)) begin
			s.mode = M_NUM;
			s.emit = 1'b1;
			s.kind = K_INT;
		end else if (is_alpha(c) || c == CH_USCORE) begin
			s.mode = M_IDENT;
			s.emit = 1'b1;
			s.kind = K_IDENT;
		end else begin
			s.emit      = 1'b1;
			s.kind      = K_OTHER;
			s.token_end = 1'b1;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

### hdl/stl_cfg.sv
`default_nettype none

module stl_cfg import stl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output logic      [LINE_W-1:0] first_line
);

	logic [LINE_W-1:0] first_line_q;

	assign pready     = 1'b1;
	assign first_line = first_line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_line_q <= LINE_W'(1);
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FIRST_LINE) begin
			first_line_q <= pwdata[LINE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_FIRST_LINE) begin
			prdata = {{(32-LINE_W){1'b0}}, first_line_q};
		end
	end

endmodule

`default_nettype wire

### hdl/stl_step.sv
`default_nettype none

module stl_step import stl_pkg::*; #(
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  wire logic [2:0]           mode,
	input  wire logic                 seen_dot,
	input  wire logic [LINE_BITS-1:0] line_count,
	input  wire logic [LINE_BITS-1:0] line_init,
	input  wire logic [7:0]           char_code,
	input  wire logic                 end_of_input,
	output logic      [2:0]           mode_nx,
	output logic                      seen_dot_nx,
	output logic      [LINE_BITS-1:0] line_nx,
	output logic      [1:0]           res_cnt,
	output res_t                      res0,
	output res_t                      res1
);

	logic [LINE_BITS+LINE_W-1:0] line_ext;
	logic [LINE_W-1:0]           line_out;
	logic [2:0]                  open_kind;
	logic                        a_v, b_v;
	res_t                        a, b;
	start_t                      st;
	logic                        nl;
	logic [7:0]                  q;

	assign line_ext = {{LINE_W{1'b0}}, line_count};
	assign line_out = line_ext[LINE_W-1:0];
	assign st       = start_tok(char_code);

	always_comb begin
		case (mode)
			M_STR, M_STR_ESC: open_kind = K_STRING;
			M_CHR, M_CHR_ESC: open_kind = K_CHAR;
			M_NUM:            open_kind = seen_dot ? K_FLOAT : K_INT;
			default:          open_kind = K_IDENT;
		endcase
	end

	always_comb begin
		mode_nx     = mode;
		seen_dot_nx = seen_dot;
		nl          = 1'b0;
		a_v         = 1'b0;
		b_v         = 1'b0;
		a           = '{kind: open_kind, has_byte: 1'b0, value_byte: 8'h00,
		                token_end: 1'b1, line: line_out};
		b           = '{kind: st.kind, has_byte: 1'b1, value_byte: char_code,
		                token_end: st.token_end, line: line_out};
		q           = (mode == M_STR) ? CH_QUOTE : CH_APOS;

		if (end_of_input) begin
			a_v         = (mode != M_IDLE) && (mode <= M_IDENT);
			b_v         = 1'b1;
			b           = '{kind: K_END, has_byte: 1'b0, value_byte: 8'h00,
			                token_end: 1'b1, line: line_out};
			mode_nx     = M_IDLE;
			seen_dot_nx = 1'b0;
		end else begin
			case (mode)
				M_STR, M_CHR: begin
					if (char_code == q) begin
						a_v     = 1'b1;
						mode_nx = M_IDLE;
					end else if (char_code == CH_BSLASH) begin
						mode_nx = (mode == M_STR) ? M_STR_ESC : M_CHR_ESC;
					end else begin
						a_v          = 1'b1;
						a.has_byte   = 1'b1;
						a.value_byte = char_code;
						a.token_end  = 1'b0;
					end
				end
				M_STR_ESC, M_CHR_ESC: begin
					mode_nx      = (mode == M_STR_ESC) ? M_STR : M_CHR;
					a_v          = 1'b1;
					a.has_byte   = 1'b1;
					a.value_byte = map_escape(char_code);
					a.token_end  = 1'b0;
				end
				M_NUM, M_IDENT: begin
					if (is_digit(char_code) ||
					    (mode == M_NUM && char_code == CH_DOT) ||
					    (mode == M_IDENT && (is_alpha(char_code) || char_code == CH_USCORE))) begin
						a_v          = 1'b1;
						a.has_byte   = 1'b1;
						a.value_byte = char_code;
						a.token_end  = 1'b0;
						if (mode == M_NUM && (seen_dot || char_code == CH_DOT)) begin
							seen_dot_nx = 1'b1;
							a.kind      = K_FLOAT;
						end
					end else begin
						// close, then hand the byte back as a fresh start
						a_v         = 1'b1;
						seen_dot_nx = 1'b0;
						mode_nx     = st.mode;
						b_v         = st.emit;
						nl          = st.newline;
					end
				end
				default: begin
					mode_nx = st.mode;
					if (st.mode == M_NUM) begin
						seen_dot_nx = 1'b0;
					end
					a_v = st.emit;
					a   = b;
					nl  = st.newline;
				end
			endcase
		end

		if (end_of_input) begin
			line_nx = line_init;
		end else if (nl && !(&line_count)) begin
			line_nx = line_count + LINE_BITS'(1);
		end else begin
			line_nx = line_count;
		end

		// pack the results towards slot zero
		res_cnt = {1'b0, a_v} + {1'b0, b_v};
		res0    = a_v ? a : b;
		res1    = b;
	end

endmodule

`default_nettype wire

### hdl/stl_rfifo.sv
`default_nettype none

module stl_rfifo import stl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] push_cnt,
	input  wire res_t       push0,
	input  wire res_t       push1,
	output logic            room,
	output logic            out_valid,
	input  wire logic       out_ready,
	output res_t            out_res
);

	localparam int PW = $clog2(DEPTH);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   cnt_q;
	logic          pop;
	logic [PW-1:0] wptr_p1;

	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rptr_q];
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= (PW+1)'(DEPTH - 2));
	assign wptr_p1   = wptr_q + PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + PW'(push_cnt);
			if (pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push_cnt) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wptr_p1] <= push1;
		end
	end

endmodule

`default_nettype wire

### hdl/source_token_lexer.sv
// Channel   Dir  Fields (lowest bit first)
// s_*       in   tdata: char_code[7:0]; tlast: end_of_input
// m_*       out  tdata: value_byte[7:0], line[31:8]; tuser: kind[2:0], has_byte[3];
//                tlast: token_end
// APB       in   register 0 at address 0: first_line[23:0]
//
// One source byte is taken per cycle while s_tready is high; the lexer state is updated at the same edge.
// Each byte gives up to two result beats into a four-entry result queue; s_tready
// stays high while the queue has room for two, so one-result bytes flow at one
// per cycle while m_tready is high; a two-result byte puts two beats in the queue.
// Reset is asynchronous and clears the lexer state and the queue; no clearing pass.
`default_nettype none

module source_token_lexer import stl_pkg::*; #(
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // char_code[7:0]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,  // value_byte[7:0], line[31:8]
	output logic      [3:0]  m_tuser,  // kind[2:0], has_byte[3]
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [2:0]           mode_q, mode_nx;
	logic                 dot_q, dot_nx;
	logic [LINE_BITS-1:0] line_q, line_nx, line_init;
	logic [LINE_W-1:0]    first_line;
	logic [LINE_BITS+LINE_W-1:0] fl_ext, fl_max;
	logic [1:0]           res_cnt;
	res_t                 res0, res1, out_res;
	logic                 take;

	stl_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.first_line
	);

	// clamp the programmed first line to the counter range
	assign fl_ext    = {{LINE_BITS{1'b0}}, first_line};
	assign fl_max    = {{LINE_W{1'b0}}, {LINE_BITS{1'b1}}};
	assign line_init = (fl_ext > fl_max) ? {LINE_BITS{1'b1}} : fl_ext[LINE_BITS-1:0];

	stl_step #(.LINE_BITS(LINE_BITS)) u_step (
		.mode         (mode_q),
		.seen_dot     (dot_q),
		.line_count   (line_q),
		.line_init    (line_init),
		.char_code    (s_tdata),
		.end_of_input (s_tlast),
		.mode_nx      (mode_nx),
		.seen_dot_nx  (dot_nx),
		.line_nx      (line_nx),
		.res_cnt      (res_cnt),
		.res0         (res0),
		.res1         (res1)
	);

	assign take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			dot_q  <= 1'b0;
			line_q <= LINE_BITS'(1);
		end else if (take) begin
			mode_q <= mode_nx;
			dot_q  <= dot_nx;
			line_q <= line_nx;
		end
	end

	stl_rfifo u_rfifo (
		.clk,
		.arst_n,
		.push_cnt  (take ? res_cnt : 2'd0),
		.push0     (res0),
		.push1     (res1),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {out_res.line, out_res.value_byte};
	assign m_tuser = {out_res.has_byte, out_res.kind};
	assign m_tlast = out_res.token_end;

endmodule

`default_nettype wire

### hdl/stl_checker.sv
`default_nettype none

module stl_checker import stl_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [3:0]  m_tuser,
	input wire logic        m_tlast
);

	// hold a stalled beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output beat changed");

	a_nobyte_closes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[3] |-> m_tlast && m_tdata[7:0] == 8'h00)
		else $error("beat without a value byte must close a token with a zero byte");

	a_end_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] == K_END |-> m_tlast && !m_tuser[3])
		else $error("end token carries a byte or is not closing");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[2:0] != 3'd7)
		else $error("unknown token kind on output");

endmodule

bind source_token_lexer stl_checker u_stl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

### verif/tb_source_token_lexer.sv
module tb_source_token_lexer;
	timeunit 1ns;
	timeprecision 1ps;
	import stl_pkg::*;

	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 80;

	localparam logic [2:0]        ADDR_FIRST_LINE = {REG_FIRST_LINE, 2'b00};
	localparam logic [2:0]        ADDR_SPARE      = 3'd4; // no register decoded here
	localparam logic [LINE_W-1:0] LINE_TOP        = {LINE_W{1'b1}};

	localparam string ESC_LETTERS = "abfnrtv";
	localparam string PUNCT       = "!#$%&()*+,-./:;<=>?@[]^`{|}~";

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;  // char_code[7:0]
	logic        s_tlast  = 1'b0;   // end_of_input
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // value_byte[7:0], line[31:8]
	logic [3:0]  m_tuser;           // kind[2:0], has_byte[3]
	logic        m_tlast;           // token_end
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = 3'd0;
	logic [31:0] pwdata   = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// lexer state as predicted from the accepted source bytes
	logic [2:0]        p_mode;
	logic              p_dot;
	logic [LINE_W-1:0] p_line;
	logic [LINE_W-1:0] cfg_first_line;

	res_t        expected_tokens[$];
	res_t        want_beat;
	int unsigned mismatches  = 0;
	int unsigned beats_seen  = 0;
	int unsigned items_sent  = 0;
	int unsigned idle_cycles = 0;
	int unsigned snd_idle_pct  = 0;
	int unsigned rcv_stall_pct = 0;
	int unsigned hold_len      = 0;

	source_token_lexer DUT (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always #2 clk = ~clk;

	function automatic logic numeral(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic word_start(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]} || c == CH_USCORE;
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] c);
		case (c)
			"a": return 8'h07;
			"b": return 8'h08;
			"f": return 8'h0C;
			"n": return 8'h0A;
			"r": return 8'h0D;
			"t": return 8'h09;
			"v": return 8'h0B;
			default: return c;
		endcase
	endfunction

	function automatic logic [2:0] open_token_kind();
		case (p_mode)
			M_STR, M_STR_ESC: return K_STRING;
			M_CHR, M_CHR_ESC: return K_CHAR;
			M_NUM: return p_dot ? K_FLOAT : K_INT;
			default: return K_IDENT;
		endcase
	endfunction

	function automatic void push_beat(input logic [2:0] kind, input logic has,
			input logic [7:0] b, input logic fin);
		res_t r;
		r.kind       = kind;
		r.has_byte   = has;
		r.value_byte = has ? b : 8'h00;
		r.token_end  = fin;
		r.line       = p_line;
		expected_tokens = {expected_tokens, r};
	endfunction

	// byte seen between tokens
	function automatic void lex_fresh(input logic [7:0] c);
		if (c <= CH_SPACE) begin
			if (c == CH_NL && p_line != LINE_TOP)
				p_line++;
		end else if (c == CH_QUOTE) begin
			p_mode = M_STR;
		end else if (c == CH_APOS) begin
			p_mode = M_CHR;
		end else if (numeral(c)) begin
			p_mode = M_NUM;
			p_dot  = 1'b0;
			push_beat(K_INT, 1'b1, c, 1'b0);
		end else if (word_start(c)) begin
			p_mode = M_IDENT;
			push_beat(K_IDENT, 1'b1, c, 1'b0);
		end else begin
			push_beat(K_OTHER, 1'b1, c, 1'b1);
		end
	endfunction

	function automatic void lex_predict(input logic [7:0] c, input logic eoi);
		logic [7:0] closer;
		if (eoi) begin
			if (p_mode != M_IDLE)
				push_beat(open_token_kind(), 1'b0, 8'h00, 1'b1);
			push_beat(K_END, 1'b0, 8'h00, 1'b1);
			p_mode = M_IDLE;
			p_dot  = 1'b0;
			p_line = cfg_first_line;
			return;
		end
		case (p_mode)
			M_STR, M_CHR: begin
				closer = (p_mode == M_STR) ? CH_QUOTE : CH_APOS;
				if (c == closer) begin
					push_beat(open_token_kind(), 1'b0, 8'h00, 1'b1);
					p_mode = M_IDLE;
				end else if (c == CH_BSLASH) begin
					p_mode = (p_mode == M_STR) ? M_STR_ESC : M_CHR_ESC;
				end else begin
					push_beat(open_token_kind(), 1'b1, c, 1'b0);
				end
			end
			M_STR_ESC, M_CHR_ESC: begin
				p_mode = (p_mode == M_STR_ESC) ? M_STR : M_CHR;
				push_beat(open_token_kind(), 1'b1, unescape(c), 1'b0);
			end
			M_NUM: begin
				if (numeral(c) || c == CH_DOT) begin
					if (c == CH_DOT)
						p_dot = 1'b1;
					push_beat(open_token_kind(), 1'b1, c, 1'b0);
				end else begin
					push_beat(open_token_kind(), 1'b0, 8'h00, 1'b1);
					p_mode = M_IDLE;
					p_dot  = 1'b0;
					lex_fresh(c);
				end
			end
			M_IDENT: begin
				if (word_start(c) || numeral(c)) begin
					push_beat(K_IDENT, 1'b1, c, 1'b0);
				end else begin
					push_beat(K_IDENT, 1'b0, 8'h00, 1'b1);
					p_mode = M_IDLE;
					lex_fresh(c);
				end
			end
			default: begin
				p_mode = M_IDLE;
				lex_fresh(c);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input int unsigned e, input int unsigned g);
		if (e != g)
			report_mismatch($sformatf("beat %0d %s expected %0h got %0h", beats_seen, name, e, g));
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (expected_tokens.size() == 0) begin
				report_mismatch($sformatf("beat %0d with nothing expected: tuser %h tdata %h",
					beats_seen, m_tuser, m_tdata));
			end else begin
				want_beat = expected_tokens.pop_front();
				check_field("kind", want_beat.kind, m_tuser[2:0]);
				check_field("has_byte", want_beat.has_byte, m_tuser[3]);
				check_field("value_byte", want_beat.value_byte, m_tdata[7:0]);
				check_field("token_end", want_beat.token_end, m_tlast);
				check_field("line", want_beat.line, m_tdata[31:8]);
			end
			beats_seen++;
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_len > 0) begin
			m_tready <= 1'b0;
			hold_len--;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_source_token_lexer failed");
		$finish;
	end

	task automatic send_item(input logic [7:0] c, input logic eoi);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eoi;
		do @(posedge clk); while (s_tready !== 1'b1);
		lex_predict(c, eoi);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic end_stream();
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	// drop valid, wait for every expected beat, then let the pipe empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_FIRST_LINE)
			cfg_first_line = data[LINE_W-1:0];
		@(posedge clk);
	endtask

	task automatic apb_read_check(input logic [2:0] addr);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[LINE_W-1:0] !== cfg_first_line)
			report_mismatch($sformatf("first_line read %h expected %h",
				prdata[LINE_W-1:0], cfg_first_line));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_word_byte(input logic lead);
		int unsigned sel;
		sel = $urandom_range(lead ? 20 : 29);
		if (sel < 10)
			return 8'h61 + 8'($urandom_range(25));
		else if (sel < 19)
			return 8'h41 + 8'($urandom_range(25));
		else if (sel < 21)
			return CH_USCORE;
		else
			return 8'h30 + 8'($urandom_range(9));
	endfunction

	task automatic send_quoted_byte();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 20) begin
			send_item(CH_BSLASH, 1'b0);
			if ($urandom_range(3) != 0)
				send_item(ESC_LETTERS[$urandom_range(6)], 1'b0);
			else
				send_item(8'($urandom_range(255)), 1'b0);
		end else if (sel < 30) begin
			send_item(8'($urandom_range(255)), 1'b0);
		end else if (sel < 35) begin
			send_item(CH_NL, 1'b0);
		end else begin
			send_item(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
		end
	endtask

	// one well-formed token with random content, a little noise, or an end of input
	task automatic send_token();
		int unsigned pick;
		int unsigned len;
		logic [7:0]  q;
		pick = $urandom_range(99);
		if (pick < 3) begin
			end_stream();
		end else if (pick < 13) begin
			repeat ($urandom_range(3, 1)) send_item(8'($urandom_range(255)), 1'b0);
		end else if (pick < 30) begin
			repeat ($urandom_range(3, 1)) begin
				case ($urandom_range(2))
					0: send_item(CH_SPACE, 1'b0);
					1: send_item(CH_NL, 1'b0);
					default: send_item(8'($urandom_range(8'h20)), 1'b0);
				endcase
			end
		end else if (pick < 50) begin
			q   = (pick < 42) ? CH_QUOTE : CH_APOS;
			len = (q == CH_QUOTE) ? $urandom_range(6) : 1;
			send_item(q, 1'b0);
			repeat (len) send_quoted_byte();
			// leave a few unterminated
			if ($urandom_range(9) != 0)
				send_item(q, 1'b0);
		end else if (pick < 65) begin
			send_item(8'h30 + 8'($urandom_range(9)), 1'b0);
			repeat ($urandom_range(5))
				send_item(($urandom_range(3) == 0) ? CH_DOT : 8'h30 + 8'($urandom_range(9)), 1'b0);
		end else if (pick < 85) begin
			send_item(rand_word_byte(1'b1), 1'b0);
			repeat ($urandom_range(5)) send_item(rand_word_byte(1'b0), 1'b0);
		end else if (pick < 93) begin
			send_item(PUNCT[$urandom_range(PUNCT.len() - 1)], 1'b0);
		end else begin
			send_item(8'($urandom_range(8'hFF, 8'h7F)), 1'b0);
		end
	endtask

	task automatic test_directed_tokens();
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		// string with an escape and a raw newline, then an empty string
		send_text("\"\\t\n\"\"\"");
		send_text("'a'");
		// char left open after a backslash, closed by end of input
		send_text("'\\");
		end_stream();
		// float handing back an ident start, ident closed by an other
		send_text("9.0x_Z0+");
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h7F, 1'b0);
		send_text("5");
		end_stream();
		settle();
	endtask

	task automatic test_first_line();
		apb_write(ADDR_SPARE, 32'h00AB_CDEF);
		apb_read_check(ADDR_FIRST_LINE);
		apb_write(ADDR_FIRST_LINE, 32'hFFFF_FFFF);
		apb_read_check(ADDR_FIRST_LINE);
		end_stream();
		// line count already at the top: newlines must not wrap it
		send_text("\n\nid\n");
		end_stream();
		settle();
		apb_write(ADDR_FIRST_LINE, 32'h0000_0000);
		apb_read_check(ADDR_FIRST_LINE);
		end_stream();
		send_text("\n7");
		end_stream();
		settle();
	endtask

	task automatic test_fill_stall();
		int unsigned stop_at;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		hold_len      = HOLD_CYCLES;
		stop_at       = items_sent + 40;
		while (items_sent < stop_at)
			send_token();
		settle();
	endtask

	task automatic test_random_traffic(input int unsigned snd, input int unsigned rcv,
			input int unsigned n, input logic [31:0] line_val);
		int unsigned stop_at;
		apb_write(ADDR_FIRST_LINE, line_val);
		apb_read_check(ADDR_FIRST_LINE);
		snd_idle_pct  = snd;
		rcv_stall_pct = rcv;
		stop_at       = items_sent + n;
		while (items_sent < stop_at)
			send_token();
		end_stream();
		settle();
	endtask

	initial begin
		cfg_first_line = LINE_W'(1);
		p_mode         = M_IDLE;
		p_dot          = 1'b0;
		p_line         = LINE_W'(1);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_tokens();
		test_first_line();
		test_fill_stall();
		test_random_traffic(0, 0, 180, $urandom);
		test_random_traffic(82, 0, 180, 32'h00FF_FFF8);
		test_random_traffic(0, 82, 180, 32'h0000_0001);
		test_random_traffic(34, 34, 180, $urandom_range(32'h00FF_FFFF));

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_tokens.size() != 0)
			report_mismatch($sformatf("%0d expected beats never arrived", expected_tokens.size()));
		if (mismatches == 0)
			$display("tb_source_token_lexer passed");
		else
			$display("tb_source_token_lexer failed");
		$finish;
	end

endmodule
